### hdl/shb_pkg.sv
// Package for the sample histogram binner.
// Holds opcodes, register indexes, fixed field widths and the types shared by the modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package shb_pkg;

    // Field widths fixed by the interface
    localparam int OP_W      = 2;
    localparam int SAMPLE_W  = 16;
    localparam int IDX_W     = 10;
    localparam int CNT_W     = 32;
    localparam int SCALE_W   = 32;
    localparam int ACT_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // Product of a 17-bit difference and a 33-bit signed scale, and its integer part
    localparam int FRAC_W = 24;
    localparam int PROD_W = SAMPLE_W + 1 + SCALE_W + 1;
    localparam int BIN_W  = PROD_W - FRAC_W;

    // Result queue
    localparam int OQ_DEPTH = 8;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_OCC_W = $clog2(OQ_DEPTH + 1);

    // Opcodes
    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALUE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_SCALE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BINS = 2'd2;

    localparam logic [CNT_W-1:0] CNT_FULL = '1;

    // Lookup request leaving the mapping stage
    typedef struct packed {
        logic             vld;
        logic [OP_W-1:0]  op;
        logic             hit;     // add that lands inside the active bins
        logic             rd_ok;   // read of a bin that exists
        logic             last;
        logic [IDX_W-1:0] idx;     // reported bin index
    } t_req;

    // One result item
    typedef struct packed {
        logic             landed;
        logic [IDX_W-1:0] bin_index;
        logic [CNT_W-1:0] bin_count;
        logic [CNT_W-1:0] max_count;
        logic             block_hit;
    } t_result;

endpackage

`default_nettype wire

### hdl/shb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read during a write to the same address returns the old contents. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module shb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hdl/shb_map.sv
// Mapping stages: input register, scale multiply, bin decision and lookup request.
// Depends on shb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module shb_map #(
    parameter int BINS = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_acc,
    input  wire logic [shb_pkg::OP_W-1:0]      i_op,
    input  wire logic [shb_pkg::SAMPLE_W-1:0]  i_sample,
    input  wire logic [shb_pkg::IDX_W-1:0]     i_ridx,
    input  wire logic                          i_last,
    input  wire logic [shb_pkg::SAMPLE_W-1:0]  i_min_value,
    input  wire logic [shb_pkg::SCALE_W-1:0]   i_bin_scale,
    input  wire logic [shb_pkg::ACT_W-1:0]     i_active_bins,
    output shb_pkg::t_req                      o_req,
    output logic      [$clog2(BINS)-1:0]       o_addr
);

    localparam int AW = $clog2(BINS);
    localparam logic [shb_pkg::BIN_W-1:0] BINS_C = shb_pkg::BIN_W'(BINS);

    // Stage A: accepted item
    logic                           r_a_vld;
    logic [shb_pkg::OP_W-1:0]       r_a_op;
    logic [shb_pkg::SAMPLE_W-1:0]   r_a_sample;
    logic [shb_pkg::IDX_W-1:0]      r_a_ridx;
    logic                           r_a_last;

    // Stage B: product
    logic                           r_b_vld;
    logic [shb_pkg::OP_W-1:0]       r_b_op;
    logic signed [shb_pkg::PROD_W-1:0] r_b_prod;
    logic [shb_pkg::IDX_W-1:0]      r_b_ridx;
    logic                           r_b_last;

    logic signed [shb_pkg::SAMPLE_W:0]   diff;
    logic signed [shb_pkg::PROD_W-1:0]   n_prod;
    logic [shb_pkg::BIN_W-1:0]           bin;
    logic [shb_pkg::BIN_W-1:0]           act_ext;
    logic [shb_pkg::BIN_W-1:0]           lim;
    logic                                add_hit;
    logic                                rd_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= i_acc;
            r_b_vld <= r_a_vld;
        end
    end

    // Capture the transaction, then the scaled offset
    always_ff @(posedge i_clk) begin
        r_a_op     <= i_op;
        r_a_sample <= i_sample;
        r_a_ridx   <= i_ridx;
        r_a_last   <= i_last;
        r_b_op     <= r_a_op;
        r_b_prod   <= n_prod;
        r_b_ridx   <= r_a_ridx;
        r_b_last   <= r_a_last;
    end

    // Offset from the lower edge times bins per unit
    always_comb begin
        diff   = $signed({r_a_sample[shb_pkg::SAMPLE_W-1], r_a_sample})
               - $signed({i_min_value[shb_pkg::SAMPLE_W-1], i_min_value});
        n_prod = shb_pkg::PROD_W'(diff) * shb_pkg::PROD_W'($signed({1'b0, i_bin_scale}));
    end

    // Floor to a bin and check it against the active range
    always_comb begin
        bin     = r_b_prod[shb_pkg::PROD_W-1:shb_pkg::FRAC_W];
        act_ext = shb_pkg::BIN_W'(i_active_bins);
        lim     = (act_ext > BINS_C) ? BINS_C : act_ext;
        add_hit = (r_b_op == shb_pkg::OP_ADD) && !r_b_prod[shb_pkg::PROD_W-1] && (bin < lim);
        rd_ok   = (r_b_op == shb_pkg::OP_READ) && (shb_pkg::BIN_W'(r_b_ridx) < BINS_C);
    end

    always_comb begin
        o_req.vld   = r_b_vld;
        o_req.op    = r_b_op;
        o_req.hit   = add_hit;
        o_req.rd_ok = rd_ok;
        o_req.last  = r_b_last;
        if (r_b_op == shb_pkg::OP_READ) begin
            o_req.idx = r_b_ridx;
            o_addr    = AW'(r_b_ridx);
        end else begin
            o_req.idx = add_hit ? bin[shb_pkg::IDX_W-1:0] : '0;
            o_addr    = bin[AW-1:0];
        end
    end

endmodule

`default_nettype wire

### hdl/shb_update.sv
// Update stage: bin counter read-modify-write with forwarding, maximum and block tracking,
// and the clearing sweep. Depends on shb_pkg and shb_ram.
`timescale 1ns / 1ps
`default_nettype none

module shb_update #(
    parameter int BINS = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire shb_pkg::t_req            i_req,
    input  wire logic [$clog2(BINS)-1:0]  i_addr,
    output logic                          o_res_vld,
    output shb_pkg::t_result              o_res,
    output logic                          o_sweep_done
);

    localparam int AW = $clog2(BINS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(BINS - 1);

    shb_pkg::t_req             r_c_req;
    logic [AW-1:0]             r_c_addr;
    logic                      r_c_fwd;
    logic [shb_pkg::CNT_W-1:0] r_c_fwd_data;
    logic [shb_pkg::CNT_W-1:0] r_max;
    logic                      r_hit_seen;
    logic                      r_sweep_on;
    logic [AW-1:0]             r_sweep_addr;

    logic [shb_pkg::CNT_W-1:0] rdata;
    logic [shb_pkg::CNT_W-1:0] old_cnt;
    logic [shb_pkg::CNT_W-1:0] new_cnt;
    logic [shb_pkg::CNT_W-1:0] n_max;
    logic                      n_hit_seen;
    logic                      seen;
    logic                      do_clear;
    logic                      we;
    logic [AW-1:0]             waddr;
    logic [shb_pkg::CNT_W-1:0] wdata;

    shb_ram #(
        .WIDTH (shb_pkg::CNT_W),
        .DEPTH (BINS)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_req.vld),
        .i_raddr (i_addr),
        .o_rdata (rdata)
    );

    // Take the newest count: bypass a write that landed with this lookup
    always_comb begin
        old_cnt  = r_c_fwd ? r_c_fwd_data : rdata;
        new_cnt  = (old_cnt == shb_pkg::CNT_FULL) ? old_cnt : old_cnt + 32'd1;
        do_clear = r_c_req.vld && (r_c_req.op == shb_pkg::OP_CLEAR);
    end

    // Write port: sweep zeroes, otherwise the incremented count
    always_comb begin
        if (r_sweep_on) begin
            we    = 1'b1;
            waddr = r_sweep_addr;
            wdata = '0;
        end else begin
            we    = r_c_req.vld && r_c_req.hit;
            waddr = r_c_addr;
            wdata = new_cnt;
        end
    end

    // Running maximum and block hit flag
    always_comb begin
        n_max      = r_max;
        n_hit_seen = r_hit_seen;
        seen       = r_hit_seen | r_c_req.hit;
        if (r_c_req.vld) begin
            if (do_clear) begin
                n_max = '0;
            end else if (r_c_req.hit && (new_cnt > r_max)) begin
                n_max = new_cnt;
            end
            n_hit_seen = r_c_req.last ? 1'b0 : seen;
        end
    end

    // Result assembly
    always_comb begin
        o_res_vld           = r_c_req.vld;
        o_res.landed        = r_c_req.hit;
        o_res.bin_index     = r_c_req.idx;
        o_res.bin_count     = (r_c_req.hit || r_c_req.rd_ok) ? (r_c_req.hit ? new_cnt : old_cnt)
                                                             : '0;
        o_res.max_count     = n_max;
        o_res.block_hit     = r_c_req.last & seen;
        o_sweep_done        = r_sweep_on && (r_sweep_addr == LAST_ADDR);
    end

    // Advance the lookup and note a write to the same bin at this edge
    always_ff @(posedge i_clk) begin
        r_c_addr     <= i_addr;
        r_c_fwd      <= we && (waddr == i_addr);
        r_c_fwd_data <= wdata;
    end

    // Control state; start a sweep after reset and after each clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_req.vld  <= 1'b0;
            r_max        <= '0;
            r_hit_seen   <= 1'b0;
            r_sweep_on   <= 1'b1;
            r_sweep_addr <= '0;
        end else begin
            r_c_req     <= i_req;
            r_max       <= n_max;
            r_hit_seen  <= n_hit_seen;
            if (do_clear) begin
                r_sweep_on   <= 1'b1;
                r_sweep_addr <= '0;
            end else if (r_sweep_on) begin
                r_sweep_on   <= (r_sweep_addr != LAST_ADDR);
                r_sweep_addr <= r_sweep_addr + AW'(1);
            end
        end
    end

endmodule

`default_nettype wire

### hdl/shb_ofifo.sv
// Result queue between the update stage and the output stream.
// Depends on shb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module shb_ofifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire shb_pkg::t_result i_data,
    input  wire logic           i_pop,
    output logic                o_valid,
    output shb_pkg::t_result    o_data
);

    shb_pkg::t_result                r_mem [shb_pkg::OQ_DEPTH];
    logic [shb_pkg::OQ_PTR_W-1:0]    r_wp;
    logic [shb_pkg::OQ_PTR_W-1:0]    r_rp;
    logic [shb_pkg::OQ_OCC_W-1:0]    r_cnt;
    logic                            pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign pop     = i_pop && o_valid;

    // Store entries; space is guaranteed by the input credit
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + shb_pkg::OQ_PTR_W'(1);
            end
            if (pop) begin
                r_rp <= r_rp + shb_pkg::OQ_PTR_W'(1);
            end
            r_cnt <= r_cnt + shb_pkg::OQ_OCC_W'(i_push) - shb_pkg::OQ_OCC_W'(pop);
        end
    end

endmodule

`default_nettype wire

### hdl/sample_histogram_binner_top.sv
// Histogram binner with maximum tracking: stream ports, configuration registers, input credit.
// Instantiates shb_map, shb_update and shb_ofifo; depends on shb_pkg.
//
// Each add transaction maps its sample to bin floor((sample - min_value) * bin_scale / 2^24)
// and counts it if that bin is non-negative and below the active bin count, capped at BINS;
// read returns a bin, clear zeroes all bins and the maximum. One transaction is taken per
// clock while s_axis_tready is high; a result passes stage A, the multiply stage B and the bin
// RAM read-modify-write stage C before it is pushed into the output queue, with back-to-back
// hits on one bin bypassed. Up to eight transactions may be outstanding before s_axis_tready
// drops. The bin RAM is swept to zero one bin per cycle: after reset and after an accepted
// clear the input is held until the sweep ends; configuration writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none

module sample_histogram_binner_top #(
    parameter int BINS = 1024
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Input stream
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [31:0]                      s_axis_tdata,  // sample[15:0], read_index[25:16]
    input  wire logic [shb_pkg::OP_W-1:0]         s_axis_tuser,  // opcode[1:0]
    input  wire logic                             s_axis_tlast,  // last_in_block
    // Output stream
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // landed[0], bin_index[10:1], bin_count[42:11], max_count[74:43], block_hit[75]
    output logic      [79:0]                      m_axis_tdata,
    // Configuration write port
    input  wire logic                             i_cfg_we,
    input  wire logic [shb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [shb_pkg::CFG_DAT_W-1:0]    i_cfg_data
);

    localparam int AW = $clog2(BINS);

    logic [shb_pkg::SAMPLE_W-1:0]  r_min_value;
    logic [shb_pkg::SCALE_W-1:0]   r_bin_scale;
    logic [shb_pkg::ACT_W-1:0]     r_active_bins;
    logic                          r_hold;
    logic [shb_pkg::OQ_OCC_W-1:0]  r_occ;

    logic                          acc;
    logic                          pop;
    shb_pkg::t_req                 req;
    logic [AW-1:0]                 addr;
    logic                          res_vld;
    shb_pkg::t_result              res;
    shb_pkg::t_result              out_res;
    logic                          sweep_done;

    // Accept while no sweep runs and the result queue has room for everything in flight
    assign s_axis_tready = !r_hold && (r_occ < shb_pkg::OQ_OCC_W'(shb_pkg::OQ_DEPTH));
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign pop           = m_axis_tvalid && m_axis_tready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_value   <= 16'h8000;
            r_bin_scale   <= '0;
            r_active_bins <= 11'd1024;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                shb_pkg::CFG_MIN_VALUE:   r_min_value   <= i_cfg_data[shb_pkg::SAMPLE_W-1:0];
                shb_pkg::CFG_BIN_SCALE:   r_bin_scale   <= i_cfg_data;
                shb_pkg::CFG_ACTIVE_BINS: r_active_bins <= i_cfg_data[shb_pkg::ACT_W-1:0];
                default: ;
            endcase
        end
    end

    // Hold input from a clear until its sweep ends; track outstanding transactions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 1'b1;
            r_occ  <= '0;
        end else begin
            if (acc && (s_axis_tuser == shb_pkg::OP_CLEAR)) begin
                r_hold <= 1'b1;
            end else if (sweep_done) begin
                r_hold <= 1'b0;
            end
            r_occ <= r_occ + shb_pkg::OQ_OCC_W'(acc) - shb_pkg::OQ_OCC_W'(pop);
        end
    end

    shb_map #(
        .BINS (BINS)
    ) u_map (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (acc),
        .i_op          (s_axis_tuser),
        .i_sample      (s_axis_tdata[15:0]),
        .i_ridx        (s_axis_tdata[25:16]),
        .i_last        (s_axis_tlast),
        .i_min_value   (r_min_value),
        .i_bin_scale   (r_bin_scale),
        .i_active_bins (r_active_bins),
        .o_req         (req),
        .o_addr        (addr)
    );

    shb_update #(
        .BINS (BINS)
    ) u_update (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .i_addr       (addr),
        .o_res_vld    (res_vld),
        .o_res        (res),
        .o_sweep_done (sweep_done)
    );

    shb_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_vld),
        .i_data  (res),
        .i_pop   (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (out_res)
    );

    // Pack the result, first field lowest
    assign m_axis_tdata = {4'b0, out_res.block_hit, out_res.max_count, out_res.bin_count,
                           out_res.bin_index, out_res.landed};

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for sample_histogram_binner_top: a directed table, then phases of random
// transactions under changing register settings, checked against the table or a histogram predictor.
// Depends on shb_pkg and the RTL under hdl/.
module tb_top;
    import shb_pkg::*;

    localparam int BINS        = 1024;
    localparam int CLK_HALF    = 2;
    localparam int RESET_CYC   = 6;
    localparam int CYCLE_LIMIT = 500000;
    localparam int IDLE_PCT    = 34;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 103;
    localparam int HOLD_AT     = 700;
    localparam int HOLD_CYC    = 300;
    localparam int DRAIN_CYC   = 8;
    localparam int TAIL_CYC    = 32;
    localparam int PAD_W       = 32 - IDX_W - SAMPLE_W;

    // Opcode that the block treats as a no-op
    localparam logic [OP_W-1:0] OP_NOP = 2'd3;

    typedef struct {
        bit             landed;
        bit [IDX_W-1:0] bin_index;
        bit [CNT_W-1:0] bin_count;
        bit [CNT_W-1:0] max_count;
        bit             block_hit;
    } bin_report_t;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [CFG_DAT_W-1:0]  cfg_data;
        logic [OP_W-1:0]       op;
        logic [SAMPLE_W-1:0]   sample;
        logic [IDX_W-1:0]      ridx;
        bit                    last;
        bit                    typed;
        bin_report_t           want;
    } stim_row_t;

    // DUT ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata;   // sample[15:0], read_index[25:16]
    logic [OP_W-1:0]       s_axis_tuser;   // opcode[1:0]
    logic                  s_axis_tlast;   // last_in_block
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // landed[0], bin_index[10:1], bin_count[42:11], max_count[74:43], block_hit[75]
    logic [79:0]           m_axis_tdata;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DAT_W-1:0]  i_cfg_data;

    // Predictor state and register copies
    bit [CNT_W-1:0]           hist_bins [BINS];
    bit [CNT_W-1:0]           peak_count;
    bit                       block_landed;
    bit signed [SAMPLE_W-1:0] cfg_min;
    bit [SCALE_W-1:0]         cfg_scale;
    bit [ACT_W-1:0]           cfg_active;

    bin_report_t         bin_reports_due [$];
    stim_row_t           dir_rows [$];
    bit [IDX_W-1:0]      last_hit_bin;
    logic [SAMPLE_W-1:0] prev_sample = '0;
    bit                  hold_done = 1'b0;

    int cycle_count  = 0;
    int fail_count   = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int settings_run = 0;
    int n_add        = 0;
    int n_landed     = 0;
    int n_read       = 0;
    int n_clear      = 0;
    int n_nop        = 0;
    int n_blocks     = 0;

    sample_histogram_binner_top #(
        .BINS(BINS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Active bin count, capped at the number of bins built
    function automatic int unsigned active_limit();
        return (cfg_active > BINS) ? BINS : cfg_active;
    endfunction

    // Compute the report for one transaction and advance the histogram
    function automatic bin_report_t predict_bin(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] sample,
                                                logic [IDX_W-1:0] ridx, bit last);
        bin_report_t rep;
        longint      diff;
        longint      prod;
        longint      bin;
        rep = '{default: '0};
        case (op)
            OP_ADD: begin
                n_add++;
                diff = longint'($signed(sample)) - longint'(cfg_min);
                prod = diff * longint'(cfg_scale);
                if (prod >= 0) begin
                    bin = prod >>> FRAC_W;
                    if (bin < longint'(active_limit())) begin
                        if (hist_bins[int'(bin)] != CNT_FULL) hist_bins[int'(bin)]++;
                        if (hist_bins[int'(bin)] > peak_count) peak_count = hist_bins[int'(bin)];
                        rep.landed    = 1'b1;
                        rep.bin_index = bin[IDX_W-1:0];
                        rep.bin_count = hist_bins[int'(bin)];
                        last_hit_bin  = bin[IDX_W-1:0];
                        n_landed++;
                    end
                end
            end
            OP_READ: begin
                n_read++;
                rep.bin_index = ridx;
                rep.bin_count = hist_bins[ridx];
            end
            OP_CLEAR: begin
                n_clear++;
                foreach (hist_bins[i]) hist_bins[i] = '0;
                peak_count = '0;
            end
            default: n_nop++;
        endcase
        if (rep.landed) block_landed = 1'b1;
        // Close the block on any flagged transaction
        if (last) begin
            rep.block_hit = block_landed;
            block_landed  = 1'b0;
            n_blocks++;
        end
        rep.max_count = peak_count;
        return rep;
    endfunction

    // Pick a sample that should fall on a random active bin
    function automatic logic [SAMPLE_W-1:0] aimed_sample();
        longint    lim;
        longint    off;
        longint    pos;
        bit [31:0] rnd;
        rnd = $urandom;
        lim = longint'(active_limit());
        if (cfg_scale == 0 || lim == 0) return rnd[SAMPLE_W-1:0];
        off = ((longint'($urandom_range(int'(lim) - 1)) << FRAC_W) + longint'(cfg_scale) - 1)
              / longint'(cfg_scale);
        pos = longint'(cfg_min) + off;
        if (pos > 32767) return rnd[SAMPLE_W-1:0];
        return pos[SAMPLE_W-1:0];
    endfunction

    function automatic bin_report_t report_of(bit landed, bit [IDX_W-1:0] idx,
                                              bit [CNT_W-1:0] cnt, bit [CNT_W-1:0] mx, bit blk);
        bin_report_t rep;
        rep.landed    = landed;
        rep.bin_index = idx;
        rep.bin_count = cnt;
        rep.max_count = mx;
        rep.block_hit = blk;
        return rep;
    endfunction

    task automatic add_cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        stim_row_t row;
        row          = '{default: '0};
        row.is_cfg   = 1'b1;
        row.cfg_idx  = idx;
        row.cfg_data = data;
        dir_rows.push_back(row);
    endtask

    task automatic add_item_row(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] sample,
                                logic [IDX_W-1:0] ridx, bit last, bit typed, bin_report_t want);
        stim_row_t row;
        row        = '{default: '0};
        row.op     = op;
        row.sample = sample;
        row.ridx   = ridx;
        row.last   = last;
        row.typed  = typed;
        row.want   = want;
        dir_rows.push_back(row);
    endtask

    // Directed rows: reset state, extremes, drops, block ends, no-op and clear
    task automatic build_table();
        bin_report_t none;
        none = report_of(0, 0, 0, 0, 0);
        add_item_row(OP_READ,  16'h0000, 10'd0,    1'b0, 1'b1, report_of(0, 0, 0, 0, 0));
        add_item_row(OP_READ,  16'hFFFF, 10'd1023, 1'b1, 1'b1, report_of(0, 1023, 0, 0, 0));
        // zero scale: everything maps to bin zero
        add_item_row(OP_ADD,   16'h8000, 10'd0,    1'b0, 1'b1, report_of(1, 0, 1, 1, 0));
        add_item_row(OP_ADD,   16'h7FFF, 10'h3FF,  1'b1, 1'b1, report_of(1, 0, 2, 2, 1));
        add_item_row(OP_NOP,   16'h5555, 10'h2AA,  1'b0, 1'b1, report_of(0, 0, 0, 2, 0));
        add_item_row(OP_CLEAR, 16'hAAAA, 10'h155,  1'b1, 1'b1, report_of(0, 0, 0, 0, 0));
        // one bin per sample unit from zero
        add_cfg_row(CFG_BIN_SCALE, 32'h0100_0000);
        add_cfg_row(CFG_MIN_VALUE, 32'h0000_0000);
        add_item_row(OP_ADD,   16'hFFFF, 10'd0,    1'b0, 1'b1, report_of(0, 0, 0, 0, 0));
        add_item_row(OP_ADD,   16'h8000, 10'd0,    1'b1, 1'b1, report_of(0, 0, 0, 0, 0));
        add_item_row(OP_ADD,   16'd1023, 10'd0,    1'b0, 1'b1, report_of(1, 1023, 1, 1, 0));
        add_item_row(OP_ADD,   16'd1024, 10'd0,    1'b0, 1'b1, report_of(0, 0, 0, 1, 0));
        // no active bins at all, then more than exist
        add_cfg_row(CFG_ACTIVE_BINS, 32'd0);
        add_item_row(OP_ADD,   16'd0,    10'd0,    1'b1, 1'b1, report_of(0, 0, 0, 1, 1));
        add_cfg_row(CFG_ACTIVE_BINS, 32'd2047);
        add_item_row(OP_ADD,   16'h7FFF, 10'd0,    1'b0, 1'b0, none);
        add_item_row(OP_ADD,   16'd5,    10'd0,    1'b0, 1'b0, none);
        add_item_row(OP_READ,  16'h0000, 10'd5,    1'b1, 1'b0, none);
        // top edge with full scale
        add_cfg_row(CFG_MIN_VALUE, 32'h0000_7FFF);
        add_cfg_row(CFG_BIN_SCALE, 32'hFFFF_FFFF);
        add_item_row(OP_ADD,   16'h7FFF, 10'd0,    1'b0, 1'b0, none);
        add_item_row(OP_ADD,   16'h8000, 10'd0,    1'b0, 1'b0, none);
        add_cfg_row(CFG_MIN_VALUE, 32'hFFFF_8000);
        add_item_row(OP_ADD,   16'h7FFF, 10'd0,    1'b0, 1'b0, none);
        add_item_row(OP_READ,  16'h0000, 10'd1023, 1'b0, 1'b0, none);
        add_item_row(OP_CLEAR, 16'h0000, 10'd0,    1'b0, 1'b0, none);
        add_item_row(OP_ADD,   16'h0000, 10'd0,    1'b1, 1'b0, none);
    endtask

    // Offer one transaction, hold it until taken, then record its expected report
    task automatic send_item(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] sample,
                             logic [IDX_W-1:0] ridx, bit last, bit typed, bin_report_t want);
        bin_report_t rep;
        int          gap;
        bit          quiet;
        gap   = 0;
        quiet = (items_sent >= 300 && items_sent < 500) || (items_sent >= 690 && items_sent < 760);
        if (!quiet) begin
            while (gap < 12 && $urandom_range(99) < IDLE_PCT) gap++;
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{PAD_W{1'b0}}, ridx, sample};
        s_axis_tuser  <= op;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        rep = predict_bin(op, sample, ridx, last);
        bin_reports_due.push_back(typed ? want : rep);
        items_sent++;
    endtask

    // Mostly adds, biased toward landing and toward repeated bins
    task automatic send_random_item();
        logic [OP_W-1:0]     op;
        logic [SAMPLE_W-1:0] sample;
        logic [IDX_W-1:0]    ridx;
        bit                  last;
        int unsigned         pick;
        bit [31:0]           rnd;
        bin_report_t         unused;
        pick = $urandom_range(99);
        if (pick < 70)      op = OP_ADD;
        else if (pick < 90) op = OP_READ;
        else if (pick < 96) op = OP_NOP;
        else                op = OP_CLEAR;
        rnd  = $urandom;
        pick = $urandom_range(99);
        if (pick < 25)      sample = prev_sample;
        else if (pick < 60) sample = aimed_sample();
        else                sample = rnd[SAMPLE_W-1:0];
        ridx        = ($urandom_range(1) == 0) ? last_hit_bin : rnd[25:16];
        last        = ($urandom_range(7) == 0);
        prev_sample = sample;
        unused      = '{default: '0};
        send_item(op, sample, ridx, last, 1'b0, unused);
    endtask

    // Drop valid and wait until every report is back and the pipe is empty
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (bin_reports_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_MIN_VALUE:   cfg_min    = data[SAMPLE_W-1:0];
            CFG_BIN_SCALE:   cfg_scale  = data;
            CFG_ACTIVE_BINS: cfg_active = data[ACT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(logic [SAMPLE_W-1:0] mn, logic [SCALE_W-1:0] sc,
                                 logic [ACT_W-1:0] act);
        drain_results();
        write_reg(CFG_MIN_VALUE, {{(CFG_DAT_W-SAMPLE_W){mn[SAMPLE_W-1]}}, mn});
        write_reg(CFG_BIN_SCALE, sc);
        write_reg(CFG_ACTIVE_BINS, {{(CFG_DAT_W-ACT_W){1'b0}}, act});
        settings_run++;
    endtask

    // Compare one output transaction with the oldest expected report
    task automatic check_result();
        bin_report_t got;
        bin_report_t want;
        got.landed    = m_axis_tdata[0];
        got.bin_index = m_axis_tdata[10:1];
        got.bin_count = m_axis_tdata[42:11];
        got.max_count = m_axis_tdata[74:43];
        got.block_hit = m_axis_tdata[75];
        results_seen++;
        if (bin_reports_due.size() == 0) begin
            $error("unexpected result transaction: %h", m_axis_tdata);
            fail_count++;
        end else begin
            want = bin_reports_due.pop_front();
            if (got.landed != want.landed) begin
                $error("landed: expected %0d, got %0d", want.landed, got.landed);
                fail_count++;
            end
            if (got.bin_index != want.bin_index) begin
                $error("bin_index: expected %0d, got %0d", want.bin_index, got.bin_index);
                fail_count++;
            end
            if (got.bin_count != want.bin_count) begin
                $error("bin_count: expected %0d, got %0d", want.bin_count, got.bin_count);
                fail_count++;
            end
            if (got.max_count != want.max_count) begin
                $error("max_count: expected %0d, got %0d", want.max_count, got.max_count);
                fail_count++;
            end
            if (got.block_hit != want.block_hit) begin
                $error("block_hit: expected %0d, got %0d", want.block_hit, got.block_hit);
                fail_count++;
            end
        end
    endtask

    // Receiver: random back-pressure, one clean stretch and one long hold-off
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) check_result();
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYC) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else if (results_seen >= 300 && results_seen < 500) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Sender: reset, directed table, random phases, drain and verdict
    initial begin
        int unsigned act;
        int unsigned span;
        int          mn;
        longint      sc;
        bit [31:0]   rnd;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        cfg_min       = 16'sh8000;
        cfg_scale     = '0;
        cfg_active    = 11'd1024;
        build_table();
        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                drain_results();
                write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_data);
            end else begin
                send_item(dir_rows[i].op, dir_rows[i].sample, dir_rows[i].ridx,
                          dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            rnd = $urandom;
            case (ph)
                0: apply_setting(16'h8000, 32'h0004_0000, 11'd1024);
                1: apply_setting(16'h0000, 32'h0100_0000, 11'(2 + $urandom_range(62)));
                2: apply_setting(rnd[15:0], $urandom, 11'($urandom_range(2047)));
                3: apply_setting(16'h7FFF, 32'hFFFF_FFFF, 11'd1);
                4: apply_setting(16'h8000, 32'h0000_0000, 11'd2047);
                6: apply_setting(rnd[15:0], $urandom, 11'd0);
                8: apply_setting(16'h8000, 32'h0004_0000, 11'd2047);
                default: begin
                    // spread the active bins over a random slice of the sample range
                    act  = 1 + $urandom_range(1023);
                    span = 1024 + $urandom_range(64511);
                    sc   = (longint'(act) << FRAC_W) / longint'(span);
                    mn   = -32768 + int'($urandom_range(65535 - span));
                    apply_setting(mn[15:0], sc[31:0], act[10:0]);
                end
            endcase
            repeat (PHASE_ITEMS) send_random_item();
        end

        drain_results();
        repeat (TAIL_CYC) @(posedge i_clk);
        $display("Covered %0d transactions under %0d register settings: %0d adds (%0d landed),",
                 items_sent, settings_run, n_add, n_landed);
        $display("%0d reads, %0d clears, %0d no-ops, %0d blocks closed, %0d mismatches",
                 n_read, n_clear, n_nop, n_blocks, fail_count);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
